>>> design/fnv1_pkg.sv
// Shared constants and types for the FNV-1 bucket index unit.
// No dependencies; used by fnv1_ctrl, fnv1_dpath and the top level.
`default_nettype none

package fnv1_pkg;

  localparam int unsigned HASH_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 25;
  localparam int unsigned INDEX_W   = 24;
  localparam int unsigned STEP_W    = 5;

  localparam logic [HASH_W-1:0]  HASH_INIT        = 32'd2166136261;
  localparam logic [HASH_W-1:0]  HASH_PRIME       = 32'd16777619;
  localparam logic [COUNT_W-1:0] BUCKETS_MAX      = 25'd16777216;
  localparam logic [COUNT_W-1:0] BUCKETS_RESET    = 25'd1024;
  localparam logic [COUNT_W-1:0] BUCKETS_MIN      = 25'd1;
  localparam logic [STEP_W-1:0]  LAST_STEP        = 5'd31;

  // controller -> datapath commands
  typedef struct packed {
    logic fold;      // word accepted: fold byte if flagged
    logic start;     // last word accepted: launch the divider
    logic step;      // one remainder bit
    logic load;      // move result to the output register
  } dp_cmd_t;

endpackage : fnv1_pkg

`default_nettype wire

>>> design/fnv1_ctrl.sv
// Controller for the FNV-1 bucket index unit: sequences hashing, the
// 32-step divider and the output register handshake. Uses fnv1_pkg.
`default_nettype none

module fnv1_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tlast,
  output logic                  s_tready,
  input  wire logic             m_tready,
  output logic                  m_tvalid,
  output fnv1_pkg::dp_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_HASH,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [fnv1_pkg::STEP_W-1:0]   step_cnt;
  logic                          accept;
  logic                          out_free;

  assign s_tready = (state == ST_HASH);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd       = '0;
    cmd.fold  = accept;
    cmd.start = accept && s_tlast;
    cmd.step  = (state == ST_DIV);
    cmd.load  = (state == ST_HOLD) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_HASH: begin
        if (accept && s_tlast) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (step_cnt == fnv1_pkg::LAST_STEP) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_HASH;
      end
      default: state_next = ST_HASH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_HASH;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) step_cnt <= step_cnt + 1'b1;
      else                 step_cnt <= '0;
      if (cmd.load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule : fnv1_ctrl

`default_nettype wire

>>> design/fnv1_dpath.sv
// Datapath for the FNV-1 bucket index unit: running hash, bucket count
// register, bit-serial restoring divider and result register. Uses fnv1_pkg.
`default_nettype none

module fnv1_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fnv1_pkg::dp_cmd_t             cmd,
  input  wire logic [fnv1_pkg::BYTE_W-1:0]   key_byte,
  input  wire logic                          byte_valid,
  input  wire logic                          cfg_we,
  input  wire logic [fnv1_pkg::COUNT_W-1:0]  cfg_data,
  output logic      [fnv1_pkg::HASH_W-1:0]   hash_value,
  output logic      [fnv1_pkg::INDEX_W-1:0]  bucket_index
);

  logic [fnv1_pkg::HASH_W-1:0]   running_hash;
  logic [fnv1_pkg::HASH_W-1:0]   hash_folded;
  logic [fnv1_pkg::HASH_W-1:0]   hash_sel;
  logic [fnv1_pkg::COUNT_W-1:0]  bucket_count;
  logic [fnv1_pkg::COUNT_W-1:0]  divisor_eff;
  logic [fnv1_pkg::COUNT_W-1:0]  divisor;
  logic [fnv1_pkg::HASH_W-1:0]   final_hash;
  logic [fnv1_pkg::HASH_W-1:0]   dividend;
  logic [fnv1_pkg::INDEX_W-1:0]  rem;
  logic [fnv1_pkg::COUNT_W-1:0]  rem_shift;
  logic [fnv1_pkg::COUNT_W-1:0]  rem_sub;

  // multiply by the prime, keep the low 32 bits, then xor the byte in
  assign hash_folded = (running_hash * fnv1_pkg::HASH_PRIME)
                       ^ {{(fnv1_pkg::HASH_W-fnv1_pkg::BYTE_W){1'b0}}, key_byte};
  assign hash_sel    = byte_valid ? hash_folded : running_hash;

  always_comb begin
    if (bucket_count == '0)                      divisor_eff = fnv1_pkg::BUCKETS_MIN;
    else if (bucket_count > fnv1_pkg::BUCKETS_MAX) divisor_eff = fnv1_pkg::BUCKETS_MAX;
    else                                         divisor_eff = bucket_count;
  end

  // remainder stays below the divisor, so one compare and subtract per bit
  assign rem_shift = {rem, dividend[fnv1_pkg::HASH_W-1]};
  assign rem_sub   = rem_shift - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= fnv1_pkg::HASH_INIT;
      bucket_count <= fnv1_pkg::BUCKETS_RESET;
    end else begin
      if (cfg_we) bucket_count <= cfg_data;
      if (cmd.start)     running_hash <= fnv1_pkg::HASH_INIT;
      else if (cmd.fold) running_hash <= hash_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      final_hash <= hash_sel;
      dividend   <= hash_sel;
      divisor    <= divisor_eff;
      rem        <= '0;
    end else if (cmd.step) begin
      dividend <= {dividend[fnv1_pkg::HASH_W-2:0], 1'b0};
      if (rem_shift >= divisor) rem <= rem_sub[fnv1_pkg::INDEX_W-1:0];
      else                      rem <= rem_shift[fnv1_pkg::INDEX_W-1:0];
    end
    if (cmd.load) begin
      hash_value   <= final_hash;
      bucket_index <= rem;
    end
  end

endmodule : fnv1_dpath

`default_nettype wire

>>> design/fnv1_bucket_index_unit.sv
// Top level of the FNV-1 bucket index unit: joins controller and datapath.
// Depends on fnv1_pkg, fnv1_ctrl and fnv1_dpath.
//
//   channel   | dir | handshake                | payload
//   ----------+-----+--------------------------+------------------------------
//   s_*       | in  | s_tvalid / s_tready      | key_byte, byte_valid, is_last
//   m_*       | out | m_tvalid / m_tready      | hash_value, bucket_index
//   cfg_*     | in  | cfg_valid / cfg_ready    | bucket_count
//
// A key byte is taken every cycle while the unit is hashing; a word with tlast
// starts the bit-serial restoring divider. Input is held off while the divider
// runs and while its result waits for a free output register. Reset (rst,
// synchronous) returns the hash to the offset basis and bucket_count to 1024.
// cfg_ready is always high.
`default_nettype none

module fnv1_bucket_index_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
  input  wire logic        s_tlast,   // is_last
  input  wire logic        s_tuser,   // [0] byte_valid
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [31:0] hash_value, [55:32] bucket_index
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [24:0] cfg_data   // bucket_count
);

  fnv1_pkg::dp_cmd_t                cmd;
  logic [fnv1_pkg::HASH_W-1:0]      hash_value;
  logic [fnv1_pkg::INDEX_W-1:0]     bucket_index;
  logic                             cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign m_tdata   = {bucket_index, hash_value};

  fnv1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  fnv1_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .key_byte     (s_tdata),
    .byte_valid   (s_tuser),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .hash_value   (hash_value),
    .bucket_index (bucket_index)
  );

`ifndef ASSERT_OFF
  // last word accepted: input held off while the divider runs
  a_hold_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !s_tready)
    else $error("input ready straight after a last word");

  // a result only appears after the controller loads it
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.load))
    else $error("output valid without a load");

  // divider never restarted mid-run
  a_no_start_in_div: assert property (@(posedge clk) disable iff (rst)
    !(cmd.start && cmd.step))
    else $error("divider start during a step");
`endif

endmodule : fnv1_bucket_index_unit

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for fnv1_bucket_index_unit: streams keys byte by byte,
// predicts FNV-1 hash and bucket per key, checks the results in order.
// Depends on fnv1_pkg and the design sources of the unit.
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WORDS_PER_PHASE = 220;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [fnv1_pkg::BYTE_W-1:0] key_byte;
    logic                        byte_valid;
    logic                        is_last;
  } key_word_t;

  typedef struct packed {
    logic [fnv1_pkg::HASH_W-1:0]  hash_value;
    logic [fnv1_pkg::INDEX_W-1:0] bucket_index;
  } bucket_result_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;   // [7:0] key_byte
  logic              s_tlast   = 1'b0; // is_last
  logic              s_tuser   = 1'b0; // [0] byte_valid
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [55:0]       m_tdata;          // [31:0] hash_value, [55:32] bucket_index
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [24:0]       cfg_data  = '0;   // bucket_count

  key_word_t         key_words_pending[$];
  bucket_result_t    bucket_results_due[$];

  logic [fnv1_pkg::HASH_W-1:0]  key_hash   = fnv1_pkg::HASH_INIT;
  logic [fnv1_pkg::COUNT_W-1:0] bucket_cfg = fnv1_pkg::BUCKETS_RESET;
  logic [fnv1_pkg::COUNT_W-1:0] live_buckets;
  logic [fnv1_pkg::HASH_W-1:0]  next_hash;
  logic [fnv1_pkg::HASH_W-1:0]  hash_mod;
  bucket_result_t               want, got;

  logic word_taken = 1'b0;
  logic cfg_taken  = 1'b0;
  logic out_taken  = 1'b0;
  logic no_idle    = 1'b0;
  logic next_valid, next_ready;
  key_word_t next_word;

  int send_gap      = 0;
  int recv_stall    = 0;
  int idle_cycles   = 0;
  int error_count   = 0;
  int results_seen  = 0;
  int keys_queued   = 0;
  int words_queued  = 0;
  int settings_used = 1;

  logic [fnv1_pkg::COUNT_W-1:0] bucket_plan [8];

  fnv1_bucket_index_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  function automatic void push_word(input logic [7:0] b, input logic v, input logic l);
    key_word_t w;
    w.key_byte   = b;
    w.byte_valid = v;
    w.is_last    = l;
    key_words_pending.push_back(w);
    if (v || l) words_queued++;
    if (l) keys_queued++;
  endfunction

  // Mostly short keys, the odd long one; stray invalid words thrown in as noise.
  function automatic void queue_random_keys(input int words);
    int target, len, i;
    target = words_queued + words;
    while (words_queued < target) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      push_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0, 1'b1);
    end
  endfunction

  task automatic wait_results();
    do @(negedge clk);
    while (key_words_pending.size() != 0 || s_tvalid || bucket_results_due.size() != 0);
  endtask

  task automatic drain();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // called at a falling edge with the unit idle
  task automatic write_buckets(input logic [fnv1_pkg::COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || word_taken)) begin
      next_valid = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
      end else if (key_words_pending.size() != 0) begin
        next_word  = key_words_pending.pop_front();
        next_valid = 1'b1;
        s_tdata <= next_word.key_byte;
        s_tuser <= next_word.byte_valid;
        s_tlast <= next_word.is_last;
        if (!no_idle && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 19);
      end
      s_tvalid <= next_valid;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      next_ready = 1'b0;
    end else if (recv_stall != 0) begin
      recv_stall--;
      next_ready = 1'b0;
    end else if (!no_idle && $urandom_range(0, 11) == 0) begin
      recv_stall = $urandom_range(1, 19) - 1;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    m_tready <= next_ready;
  end

  // predictor, checker and watchdog
  always @(posedge clk) begin
    word_taken = s_tvalid && s_tready;
    cfg_taken  = cfg_valid && cfg_ready;
    out_taken  = m_tvalid && m_tready;
    if (rst) begin
      key_hash    = fnv1_pkg::HASH_INIT;
      bucket_cfg  = fnv1_pkg::BUCKETS_RESET;
      idle_cycles = 0;
    end else begin
      if (cfg_taken) bucket_cfg = cfg_data;
      if (word_taken) begin
        next_hash = key_hash;
        if (s_tuser) next_hash = (next_hash * fnv1_pkg::HASH_PRIME) ^ {24'd0, s_tdata};
        if (s_tlast) begin
          // zero behaves as one bucket, anything past the maximum is clamped
          if (bucket_cfg == '0) live_buckets = fnv1_pkg::BUCKETS_MIN;
          else if (bucket_cfg > fnv1_pkg::BUCKETS_MAX) live_buckets = fnv1_pkg::BUCKETS_MAX;
          else live_buckets = bucket_cfg;
          hash_mod          = next_hash % {7'd0, live_buckets};
          want.hash_value   = next_hash;
          want.bucket_index = hash_mod[fnv1_pkg::INDEX_W-1:0];
          bucket_results_due.push_back(want);
          key_hash = fnv1_pkg::HASH_INIT;
        end else begin
          key_hash = next_hash;
        end
      end
      if (out_taken) begin
        got.hash_value   = m_tdata[31:0];
        got.bucket_index = m_tdata[55:32];
        if (bucket_results_due.size() == 0) begin
          flag_error($sformatf("result word with none due: hash %h bucket %0d",
                               got.hash_value, got.bucket_index));
        end else begin
          want = bucket_results_due.pop_front();
          results_seen++;
          if (got.hash_value !== want.hash_value)
            flag_error($sformatf("hash_value: expected %h, got %h",
                                 want.hash_value, got.hash_value));
          if (got.bucket_index !== want.bucket_index)
            flag_error($sformatf("bucket_index (hash %h): expected %0d, got %0d",
                                 want.hash_value, want.bucket_index, got.bucket_index));
        end
      end
      if (word_taken || cfg_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("fnv1_bucket_index_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int p;
    bucket_plan[0] = 25'd1;
    bucket_plan[1] = fnv1_pkg::BUCKETS_MAX;
    bucket_plan[2] = 25'd0;
    bucket_plan[3] = 25'h1FFFFFF;
    bucket_plan[4] = 25'd16777215;
    bucket_plan[5] = 25'd3;
    bucket_plan[6] = 25'($urandom_range(2, 16777216));
    bucket_plan[7] = fnv1_pkg::BUCKETS_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed keys at the reset bucket count
    push_word(8'h00, 1'b0, 1'b1);                 // empty key
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'hFF, 1'b1, 1'b1);
    push_word(8'h5A, 1'b0, 1'b0);                 // ignored word before a key
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'hA5, 1'b0, 1'b0);                 // ignored word mid-key
    push_word(8'h62, 1'b1, 1'b1);
    push_word(8'h80, 1'b1, 1'b0);
    push_word(8'h7F, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 1'b1);                 // last word carries no byte
    push_word(8'hFF, 1'b1, 1'b0);
    push_word(8'hFF, 1'b1, 1'b0);
    push_word(8'hFF, 1'b1, 1'b0);
    push_word(8'hFF, 1'b1, 1'b1);
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'h33, 1'b0, 1'b0);
    push_word(8'hCC, 1'b0, 1'b1);                 // only ignored words, then empty end
    queue_random_keys(WORDS_PER_PHASE);
    drain();

    for (p = 0; p < 8; p++) begin
      if (p == 7) no_idle = 1'b1;
      write_buckets(bucket_plan[p]);
      @(posedge clk);
      if (p == 2) begin
        // sender holds off mid-phase until every result is back
        queue_random_keys(WORDS_PER_PHASE / 2);
        wait_results();
        @(posedge clk);
        queue_random_keys(WORDS_PER_PHASE / 2);
      end else begin
        queue_random_keys(WORDS_PER_PHASE);
      end
      drain();
    end

    if (bucket_results_due.size() != 0)
      flag_error($sformatf("%0d results never arrived", bucket_results_due.size()));

    $display("Covered %0d keys in %0d key words over %0d bucket counts, incl. 0 and oversize.",
             keys_queued, words_queued, settings_used);
    $display("%0d results compared, %0d mismatches.", results_seen, error_count);
    if (error_count == 0) begin
      $display("fnv1_bucket_index_unit verification clean");
    end else begin
      $display("fnv1_bucket_index_unit verification failed");
    end
    $finish;
  end

endmodule
